FILE: hw/rtl/lobm_pkg.sv
// shared types, constants and helpers of the linear octree boolean merge block
package lobm_pkg;

  localparam int LEVEL_W   = 4;
  localparam int ENTRY_W   = 5;
  localparam int VOL_W     = 46;
  localparam int OUT_VOL_W = 31;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [OUT_VOL_W-1:0] VOL_LIMIT = '1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MALFORMED = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DO_UNION  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'b1;

  localparam logic                 DO_UNION_RST  = 1'b1;
  localparam logic [LEVEL_W-1:0]   MAX_LEVEL_RST = 4'd10;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK,
    ST_DELIVER
  } lobm_state_e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_FETCH,
    W_EVAL,
    W_SFETCH,
    W_SEVAL,
    W_FINISH,
    W_FAIL
  } walk_state_e;

  typedef struct packed {
    logic               start;
    logic               op;
    logic [LEVEL_W-1:0] top;
  } walk_cmd_t;

  typedef struct packed {
    logic                 done;
    logic                 ok;
    logic [OUT_VOL_W-1:0] volume;
    logic                 changed;
  } walk_res_t;

  // finest cubes inside one cube at level lvl, that is 8^(top-lvl)
  function automatic logic [VOL_W-1:0] cube_units(logic [LEVEL_W-1:0] lvl,
                                                  logic [LEVEL_W-1:0] top);
    logic [LEVEL_W-1:0] d;
    logic [5:0]         sh;
    d  = top - lvl;
    sh = {2'b00, d} + {1'b0, d, 1'b0};
    return VOL_W'(1) << sh;
  endfunction

endpackage

FILE: hw/rtl/lobm_if.sv
// handshake channels of the octree merge block: leaf input, result output, register writes
interface lobm_leaf_if;
  logic                         valid;
  logic                         ready;
  logic                         tree_side;
  logic                         is_full;
  logic [lobm_pkg::LEVEL_W-1:0] leaf_level;
  logic                         last;

  modport source (output valid, tree_side, is_full, leaf_level, last, input ready);
  modport sink   (input valid, tree_side, is_full, leaf_level, last, output ready);
endinterface

interface lobm_res_if;
  logic                           valid;
  logic                           ready;
  logic [lobm_pkg::OUT_VOL_W-1:0] occupied_volume;
  logic                           changed;
  logic [lobm_pkg::STATUS_W-1:0]  status;

  modport source (output valid, occupied_volume, changed, status, input ready);
  modport sink   (input valid, occupied_volume, changed, status, output ready);
endinterface

interface lobm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lobm_pkg::CFG_IDX_W-1:0] index;
  logic [lobm_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/lobm_ram.sv
// generic single write port ram with one registered read port
module lobm_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lobm_walk.sv
// merge walker: steps through both leaf memories and sums the occupied volume
module lobm_walk #(
  parameter int TREE_DEPTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lobm_pkg::walk_cmd_t                 cmd_i,
  input  logic [$clog2(TREE_DEPTH+1)-1:0]     left_len_i,
  input  logic [$clog2(TREE_DEPTH+1)-1:0]     right_len_i,
  input  logic [lobm_pkg::ENTRY_W-1:0]        left_data_i,
  input  logic [lobm_pkg::ENTRY_W-1:0]        right_data_i,
  output logic                                left_re_o,
  output logic                                right_re_o,
  output logic [$clog2(TREE_DEPTH)-1:0]       left_addr_o,
  output logic [$clog2(TREE_DEPTH)-1:0]       right_addr_o,
  output lobm_pkg::walk_res_t                 res_o
);

  localparam int LEN_W  = $clog2(TREE_DEPTH + 1);
  localparam int ADDR_W = $clog2(TREE_DEPTH);
  localparam int VW     = lobm_pkg::VOL_W;
  localparam int LW     = lobm_pkg::LEVEL_W;

  lobm_pkg::walk_state_e state_q, state_d;

  logic [VW-1:0]    off_q, off_d;
  logic [VW-1:0]    vol_q, vol_d;
  logic [VW-1:0]    sub_off_q, sub_off_d;
  logic [VW-1:0]    span_q, span_d;
  logic [LEN_W-1:0] lp_q, lp_d, rp_q, rp_d;
  logic [LW-1:0]    sub_lvl_q, sub_lvl_d;
  logic             sub_side_q, sub_side_d;
  logic             cnt_q, cnt_d;
  logic             chg_q, chg_d;
  logic             ok_q, ok_d;
  logic             done_q, done_d;

  // decode of the current pair of leaves and of the current subtree leaf
  logic [LW-1:0] top, ll, rl, sl;
  logic          lf, rf, sf, op;
  logic [VW-1:0] total, u_l, u_r, u_s, u_main, off_sum, sub_sum;
  logic          main_bad, main_eq, main_lt, main_end, occ;
  logic          sub_bad, sub_end, lp_ok, rp_ok, pos_ok;
  logic [lobm_pkg::ENTRY_W-1:0] sd;

  always_comb begin
    top      = cmd_i.top;
    op       = cmd_i.op;
    total    = lobm_pkg::cube_units('0, top);
    ll       = left_data_i[LW-1:0];
    rl       = right_data_i[LW-1:0];
    lf       = left_data_i[LW];
    rf       = right_data_i[LW];
    u_l      = lobm_pkg::cube_units(ll, top);
    u_r      = lobm_pkg::cube_units(rl, top);
    main_bad = (ll > top) || (rl > top) || (|(off_q & (u_l - VW'(1))))
               || (|(off_q & (u_r - VW'(1))));
    main_eq  = (ll == rl);
    main_lt  = (ll < rl);
    u_main   = (ll <= rl) ? u_l : u_r;
    off_sum  = off_q + u_main;
    main_end = (off_sum == total);
    occ      = op ? (lf | rf) : (lf & rf);

    sd       = sub_side_q ? right_data_i : left_data_i;
    sl       = sd[LW-1:0];
    sf       = sd[LW];
    u_s      = lobm_pkg::cube_units(sl, top);
    sub_bad  = (sl < sub_lvl_q) || (sl > top) || (|(sub_off_q & (u_s - VW'(1))));
    sub_sum  = sub_off_q + u_s;
    sub_end  = (sub_sum == span_q);

    lp_ok    = (lp_q < left_len_i);
    rp_ok    = (rp_q < right_len_i);
    pos_ok   = sub_side_q ? rp_ok : lp_ok;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lobm_pkg::W_IDLE: begin
        if (cmd_i.start) state_d = lobm_pkg::W_FETCH;
      end
      lobm_pkg::W_FETCH: begin
        state_d = (lp_ok && rp_ok) ? lobm_pkg::W_EVAL : lobm_pkg::W_FAIL;
      end
      lobm_pkg::W_EVAL: begin
        if (main_bad) begin
          state_d = lobm_pkg::W_FAIL;
        end else if (main_eq) begin
          state_d = main_end ? lobm_pkg::W_FINISH : lobm_pkg::W_FETCH;
        end else begin
          // first leaf of the finer subtree is already read
          state_d = lobm_pkg::W_SEVAL;
        end
      end
      lobm_pkg::W_SFETCH: begin
        state_d = pos_ok ? lobm_pkg::W_SEVAL : lobm_pkg::W_FAIL;
      end
      lobm_pkg::W_SEVAL: begin
        if (sub_bad) begin
          state_d = lobm_pkg::W_FAIL;
        end else if (!sub_end) begin
          state_d = lobm_pkg::W_SFETCH;
        end else begin
          state_d = (off_q == total) ? lobm_pkg::W_FINISH : lobm_pkg::W_FETCH;
        end
      end
      lobm_pkg::W_FINISH: state_d = lobm_pkg::W_IDLE;
      lobm_pkg::W_FAIL:   state_d = lobm_pkg::W_IDLE;
      default:            state_d = lobm_pkg::W_IDLE;
    endcase
  end

  always_comb begin
    off_d      = off_q;
    vol_d      = vol_q;
    sub_off_d  = sub_off_q;
    span_d     = span_q;
    lp_d       = lp_q;
    rp_d       = rp_q;
    sub_lvl_d  = sub_lvl_q;
    sub_side_d = sub_side_q;
    cnt_d      = cnt_q;
    chg_d      = chg_q;
    ok_d       = ok_q;
    done_d     = 1'b0;
    left_re_o  = 1'b0;
    right_re_o = 1'b0;
    unique case (state_q)
      lobm_pkg::W_IDLE: begin
        if (cmd_i.start) begin
          off_d = '0;
          vol_d = '0;
          lp_d  = '0;
          rp_d  = '0;
          chg_d = 1'b0;
        end
      end
      lobm_pkg::W_FETCH: begin
        left_re_o  = 1'b1;
        right_re_o = 1'b1;
      end
      lobm_pkg::W_EVAL: begin
        if (!main_bad) begin
          off_d     = off_sum;
          sub_off_d = '0;
          if (main_eq) begin
            lp_d = lp_q + LEN_W'(1);
            rp_d = rp_q + LEN_W'(1);
            if (occ) vol_d = vol_q + u_l;
            if (occ != lf) chg_d = 1'b1;
          end else if (main_lt) begin
            // coarse left leaf against a right subtree
            lp_d       = lp_q + LEN_W'(1);
            span_d     = u_l;
            sub_lvl_d  = ll;
            sub_side_d = 1'b1;
            if (lf == op) begin
              if (op) vol_d = vol_q + u_l;
              cnt_d = 1'b0;
            end else begin
              cnt_d = 1'b1;
              chg_d = 1'b1;
            end
          end else begin
            // coarse right leaf against a left subtree
            rp_d       = rp_q + LEN_W'(1);
            span_d     = u_r;
            sub_lvl_d  = rl;
            sub_side_d = 1'b0;
            if (rf == op) begin
              if (op) vol_d = vol_q + u_r;
              cnt_d = 1'b0;
              chg_d = 1'b1;
            end else begin
              cnt_d = 1'b1;
            end
          end
        end
      end
      lobm_pkg::W_SFETCH: begin
        left_re_o  = !sub_side_q;
        right_re_o = sub_side_q;
      end
      lobm_pkg::W_SEVAL: begin
        if (!sub_bad) begin
          if (cnt_q && sf) vol_d = vol_q + u_s;
          sub_off_d = sub_sum;
          if (sub_side_q) begin
            rp_d = rp_q + LEN_W'(1);
          end else begin
            lp_d = lp_q + LEN_W'(1);
          end
        end
      end
      lobm_pkg::W_FINISH: begin
        ok_d   = (lp_q == left_len_i) && (rp_q == right_len_i);
        done_d = 1'b1;
      end
      lobm_pkg::W_FAIL: begin
        ok_d   = 1'b0;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign left_addr_o  = lp_q[ADDR_W-1:0];
  assign right_addr_o = rp_q[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lobm_pkg::W_IDLE;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q      <= off_d;
    vol_q      <= vol_d;
    sub_off_q  <= sub_off_d;
    span_q     <= span_d;
    lp_q       <= lp_d;
    rp_q       <= rp_d;
    sub_lvl_q  <= sub_lvl_d;
    sub_side_q <= sub_side_d;
    cnt_q      <= cnt_d;
    chg_q      <= chg_d;
  end

  // result stays stable while idle after the done pulse
  always_comb begin
    res_o.done    = done_q;
    res_o.ok      = ok_q;
    res_o.changed = ok_q & chg_q;
    if (!ok_q) begin
      res_o.volume = '0;
    end else if (|vol_q[VW-1:lobm_pkg::OUT_VOL_W]) begin
      res_o.volume = lobm_pkg::VOL_LIMIT;
    end else begin
      res_o.volume = vol_q[lobm_pkg::OUT_VOL_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/linear_octree_boolean_merge_core.sv
// linear octree union/intersection volume unit: leaf loading, merge walk, result register
// loading takes one leaf beat per cycle; leaves wait during the walk and the result delivery
// the walk starts the cycle after the second list completes; a step retiring one leaf of
// each list or one subtree leaf reads then evaluates; a subtree's first leaf only evaluates
// result beat registered from the deliver state, entered on the walk's done or on a load error
// reset clears lengths, flags, errors and registers; the leaf memories need no clearing
module linear_octree_boolean_merge_core #(
  parameter int TREE_DEPTH = 4096,
  parameter int LEVEL_MAX  = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lobm_cfg_if.sink    cfg_i,
  lobm_leaf_if.sink   leaf_i,
  lobm_res_if.source  res_o
);

  localparam int LEN_W  = $clog2(TREE_DEPTH + 1);
  localparam int ADDR_W = $clog2(TREE_DEPTH);
  localparam int LW     = lobm_pkg::LEVEL_W;
  localparam int EW     = lobm_pkg::ENTRY_W;
  localparam int SW     = lobm_pkg::STATUS_W;

  lobm_pkg::lobm_state_e state_q, state_d;

  logic                 do_union_q;
  logic [LW-1:0]        max_level_q;
  logic [LEN_W-1:0]     left_len_q, left_len_d, right_len_q, right_len_d;
  logic [1:0]           sides_q, sides_d;
  logic [SW-1:0]        err_q, err_d;
  logic                 res_valid_q, res_valid_d;
  logic [lobm_pkg::OUT_VOL_W-1:0] res_vol_q;
  logic                 res_chg_q;
  logic [SW-1:0]        res_status_q;

  logic                 leaf_fire, side_open, lvl_bad, mem_full, pair_done;
  logic [LEN_W-1:0]     cur_len;
  logic [1:0]           side_bit;
  logic                 load_out;

  logic                 left_we, right_we, left_re, right_re;
  logic [ADDR_W-1:0]    left_raddr, right_raddr;
  logic [EW-1:0]        left_rdata, right_rdata, wdata;

  lobm_pkg::walk_cmd_t  walk_cmd;
  lobm_pkg::walk_res_t  walk_res;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      do_union_q  <= lobm_pkg::DO_UNION_RST;
      max_level_q <= lobm_pkg::MAX_LEVEL_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lobm_pkg::CFG_DO_UNION:  do_union_q  <= cfg_i.data[0];
        lobm_pkg::CFG_MAX_LEVEL: max_level_q <= cfg_i.data[LW-1:0];
        default: ;
      endcase
    end
  end

  // leaf loading
  assign leaf_fire = leaf_i.valid && leaf_i.ready;
  assign side_bit  = leaf_i.tree_side ? 2'b10 : 2'b01;
  assign side_open = !(|(sides_q & side_bit));
  assign cur_len   = leaf_i.tree_side ? right_len_q : left_len_q;
  assign mem_full  = (cur_len == LEN_W'(TREE_DEPTH));
  assign lvl_bad   = (leaf_i.leaf_level > max_level_q) ||
                     (leaf_i.leaf_level > LW'(LEVEL_MAX));
  assign wdata     = {leaf_i.is_full, leaf_i.leaf_level};
  assign left_we   = leaf_fire && side_open && !mem_full && !leaf_i.tree_side;
  assign right_we  = leaf_fire && side_open && !mem_full && leaf_i.tree_side;

  always_comb begin
    left_len_d  = left_len_q;
    right_len_d = right_len_q;
    sides_d     = sides_q;
    err_d       = err_q;
    if (leaf_fire && side_open) begin
      if (err_d == lobm_pkg::STAT_OK && lvl_bad) err_d = lobm_pkg::STAT_MALFORMED;
      if (mem_full) begin
        if (err_d == lobm_pkg::STAT_OK) err_d = lobm_pkg::STAT_OVERFLOW;
      end else if (leaf_i.tree_side) begin
        right_len_d = right_len_q + LEN_W'(1);
      end else begin
        left_len_d = left_len_q + LEN_W'(1);
      end
      if (leaf_i.last) sides_d = sides_q | side_bit;
    end
    if (load_out) begin
      left_len_d  = '0;
      right_len_d = '0;
      sides_d     = '0;
      err_d       = lobm_pkg::STAT_OK;
    end
  end

  assign pair_done = leaf_fire && side_open && (sides_d == 2'b11);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lobm_pkg::ST_LOAD: begin
        if (pair_done) begin
          state_d = (err_d == lobm_pkg::STAT_OK) ? lobm_pkg::ST_WALK : lobm_pkg::ST_DELIVER;
        end
      end
      lobm_pkg::ST_WALK: begin
        if (walk_res.done) state_d = lobm_pkg::ST_DELIVER;
      end
      lobm_pkg::ST_DELIVER: begin
        if (!res_valid_q || res_o.ready) state_d = lobm_pkg::ST_LOAD;
      end
      default: state_d = lobm_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    leaf_i.ready   = (state_q == lobm_pkg::ST_LOAD);
    walk_cmd.start = (state_q == lobm_pkg::ST_LOAD) && pair_done &&
                     (err_d == lobm_pkg::STAT_OK);
    walk_cmd.op    = do_union_q;
    walk_cmd.top   = max_level_q;
    load_out       = (state_q == lobm_pkg::ST_DELIVER) && (!res_valid_q || res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lobm_pkg::ST_LOAD;
      left_len_q  <= '0;
      right_len_q <= '0;
      sides_q     <= '0;
      err_q       <= lobm_pkg::STAT_OK;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_len_q  <= left_len_d;
      right_len_q <= right_len_d;
      sides_q     <= sides_d;
      err_q       <= err_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result register, refilled as soon as the previous beat leaves
  always_comb begin
    res_valid_d = res_valid_q;
    if (load_out) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (err_q != lobm_pkg::STAT_OK) begin
        res_status_q <= err_q;
        res_vol_q    <= '0;
        res_chg_q    <= 1'b0;
      end else begin
        res_status_q <= walk_res.ok ? lobm_pkg::STAT_OK : lobm_pkg::STAT_MALFORMED;
        res_vol_q    <= walk_res.volume;
        res_chg_q    <= walk_res.changed;
      end
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.occupied_volume = res_vol_q;
  assign res_o.changed         = res_chg_q;
  assign res_o.status          = res_status_q;

  lobm_ram #(
    .WIDTH (EW),
    .DEPTH (TREE_DEPTH)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_len_q[ADDR_W-1:0]),
    .wdata_i (wdata),
    .re_i    (left_re),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  lobm_ram #(
    .WIDTH (EW),
    .DEPTH (TREE_DEPTH)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_len_q[ADDR_W-1:0]),
    .wdata_i (wdata),
    .re_i    (right_re),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  lobm_walk #(
    .TREE_DEPTH (TREE_DEPTH)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (walk_cmd),
    .left_len_i   (left_len_q),
    .right_len_i  (right_len_q),
    .left_data_i  (left_rdata),
    .right_data_i (right_rdata),
    .left_re_o    (left_re),
    .right_re_o   (right_re),
    .left_addr_o  (left_raddr),
    .right_addr_o (right_raddr),
    .res_o        (walk_res)
  );

endmodule

FILE: hw/rtl/lobm_checker.sv
// port level checks of the octree merge block and their bind to the top level
module lobm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [lobm_pkg::OUT_VOL_W-1:0] res_volume_i,
  input logic                           res_changed_i,
  input logic [lobm_pkg::STATUS_W-1:0]  res_status_i
);

  // a stalled result beat keeps its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_volume_i) &&
                                    $stable(res_changed_i) && $stable(res_status_i))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_status_i == lobm_pkg::STAT_OK) ||
                    (res_status_i == lobm_pkg::STAT_OVERFLOW) ||
                    (res_status_i == lobm_pkg::STAT_MALFORMED))
    else $error("unknown status code");

  // an error result carries no volume and no change flag
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i != lobm_pkg::STAT_OK) |->
      (res_volume_i == '0) && !res_changed_i)
    else $error("error result with payload");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !res_valid_i)
    else $error("result beat right after reset");

endmodule

bind linear_octree_boolean_merge_core lobm_checker u_lobm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_volume_i  (res_o.occupied_volume),
  .res_changed_i (res_o.changed),
  .res_status_i  (res_o.status)
);
